>>> rtl/etq_pkg.sv
// ----------------------------------------------------------------------------
// etq_pkg
// Shared constants, codes and controller/datapath interface types for the
// expiring timer queue.
// ----------------------------------------------------------------------------
package etq_pkg;

  localparam int unsigned CAPACITY = 32;
  localparam int unsigned IDX_W    = $clog2(CAPACITY);
  localparam int unsigned PTR_W    = $clog2(CAPACITY + 1);
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned CNT_W    = 6;
  localparam int unsigned ENTRY_W  = 2 * DATA_W;

  typedef enum logic [1:0] {
    MODE_ADD    = 2'd0,
    MODE_REMOVE = 2'd1,
    MODE_CLEAR  = 2'd2,
    MODE_POP    = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD,
    ST_CLEAR,
    ST_SCAN,
    ST_EVAL
  } state_e;

  typedef struct packed {
    logic load;
    logic do_add;
    logic do_clear;
    logic scan_run;
    logic rem_done;
    logic pop_hit;
    logic pop_end;
  } cmd_t;

  typedef struct packed {
    mode_e mode;
    logic  scan_done;
    logic  best_vld;
  } sts_t;

endpackage

>>> rtl/expiring_timer_queue.sv
// ----------------------------------------------------------------------------
// expiring_timer_queue
// Bounded timer table with add, cancel by id, cancel all and pop-expired.
// ----------------------------------------------------------------------------
// Add and remove-all: accepted in IDLE, dispatched from SCAN, run in ADD or CLEAR; the result strobe is registered.
// Remove: one table scan through the single RAM read port, then an evaluation step.
// Pop of k timers: k + 1 table scans, each followed by an evaluation; one result per hit, then an end result.
// Results are strobed for one cycle; the receiver cannot stall them.
// Reset clears all valid bits and the id counter at once; no clearing pass.
module expiring_timer_queue (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic [1:0]                  mode_i,
  input  logic [etq_pkg::DATA_W-1:0]  expire_time_i,
  input  logic [etq_pkg::DATA_W-1:0]  job_id_i,
  input  logic [etq_pkg::DATA_W-1:0]  now_time_i,
  output logic                        result_valid_o,
  output logic [etq_pkg::DATA_W-1:0]  result_id_o,
  output logic                        found_o,
  output logic                        full_error_o,
  output logic [etq_pkg::CNT_W-1:0]   expired_count_o,
  output logic                        last_o
);
  import etq_pkg::*;

  cmd_t cmd;
  sts_t sts;

  etq_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .sts_i   (sts),
    .cmd_o   (cmd)
  );

  etq_dpath u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .mode_i          (mode_i),
    .expire_time_i   (expire_time_i),
    .job_id_i        (job_id_i),
    .now_time_i      (now_time_i),
    .result_valid_o  (result_valid_o),
    .result_id_o     (result_id_o),
    .found_o         (found_o),
    .full_error_o    (full_error_o),
    .expired_count_o (expired_count_o),
    .last_o          (last_o)
  );

endmodule

>>> rtl/etq_ram.sv
// ----------------------------------------------------------------------------
// etq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module etq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/etq_ctrl.sv
// ----------------------------------------------------------------------------
// etq_ctrl
// Command sequencer: accepts a command, runs table scans and issues the
// result steps to the datapath.
// ----------------------------------------------------------------------------
module etq_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  output logic          busy_o,
  input  etq_pkg::sts_t sts_i,
  output etq_pkg::cmd_t cmd_o
);
  import etq_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // mode is loaded on the accept edge, so dispatch from here
        unique case (sts_i.mode)
          MODE_ADD:   state_d = ST_ADD;
          MODE_CLEAR: state_d = ST_CLEAR;
          default: begin
            if (sts_i.scan_done) begin
              state_d = ST_EVAL;
            end
          end
        endcase
      end
      ST_ADD:   state_d = ST_IDLE;
      ST_CLEAR: state_d = ST_IDLE;
      ST_EVAL: begin
        if (sts_i.mode == MODE_POP && sts_i.best_vld) begin
          state_d = ST_SCAN;
        end else begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o  = '0;
    busy_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        busy_o     = 1'b0;
        cmd_o.load = start_i;
      end
      ST_SCAN: begin
        cmd_o.scan_run = (sts_i.mode == MODE_REMOVE) || (sts_i.mode == MODE_POP);
      end
      ST_ADD:   cmd_o.do_add   = 1'b1;
      ST_CLEAR: cmd_o.do_clear = 1'b1;
      ST_EVAL: begin
        if (sts_i.mode == MODE_POP) begin
          cmd_o.pop_hit = sts_i.best_vld;
          cmd_o.pop_end = !sts_i.best_vld;
        end else begin
          cmd_o.rem_done = 1'b1;
        end
      end
      default: busy_o = 1'b1;
    endcase
  end

endmodule

>>> rtl/etq_dpath.sv
// ----------------------------------------------------------------------------
// etq_dpath
// Timer table datapath: valid bits, id/expiry RAM, scan pipeline, best-entry
// tracker, id counter and the registered result port.
// ----------------------------------------------------------------------------
module etq_dpath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  etq_pkg::cmd_t               cmd_i,
  output etq_pkg::sts_t               sts_o,
  input  logic [1:0]                  mode_i,
  input  logic [etq_pkg::DATA_W-1:0]  expire_time_i,
  input  logic [etq_pkg::DATA_W-1:0]  job_id_i,
  input  logic [etq_pkg::DATA_W-1:0]  now_time_i,
  output logic                        result_valid_o,
  output logic [etq_pkg::DATA_W-1:0]  result_id_o,
  output logic                        found_o,
  output logic                        full_error_o,
  output logic [etq_pkg::CNT_W-1:0]   expired_count_o,
  output logic                        last_o
);
  import etq_pkg::*;

  localparam logic [PTR_W-1:0] PtrEnd = PTR_W'(CAPACITY);

  // command operands
  mode_e             mode_q;
  logic [DATA_W-1:0] exp_q, jid_q, now_q;

  logic [CAPACITY-1:0] valid_q, valid_d;
  logic [DATA_W-1:0]   next_id_q;

  // scan pipeline
  logic [PTR_W-1:0] ptr_q;
  logic             chk_q;
  logic [IDX_W-1:0] chk_slot_q;
  logic [ENTRY_W-1:0] rdata;
  logic [DATA_W-1:0]  rd_exp, rd_id;

  // best candidate / remove hit
  logic              best_vld_q;
  logic [IDX_W-1:0]  best_slot_q;
  logic [DATA_W-1:0] best_exp_q, best_id_q;
  logic [PTR_W-1:0]  count_q;

  logic [IDX_W-1:0] free_slot;
  logic             full;
  logic             cur_vld, rem_hit, pop_elig, pop_better;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q <= mode_e'(mode_i);
      exp_q  <= expire_time_i;
      jid_q  <= job_id_i;
      now_q  <= now_time_i;
    end
  end

  // lowest free slot
  always_comb begin
    free_slot = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_slot = IDX_W'(i);
      end
    end
  end
  assign full = &valid_q;

  etq_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(CAPACITY)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (cmd_i.do_add && !full),
    .waddr_i (free_slot),
    .wdata_i ({exp_q, next_id_q}),
    .raddr_i (ptr_q[IDX_W-1:0]),
    .rdata_o (rdata)
  );

  assign rd_exp = rdata[ENTRY_W-1:DATA_W];
  assign rd_id  = rdata[DATA_W-1:0];

  assign cur_vld    = chk_q && valid_q[chk_slot_q];
  assign rem_hit    = cur_vld && (rd_id == jid_q) && !best_vld_q;
  assign pop_elig   = cur_vld && (rd_exp <= now_q);
  // strict compares keep the lower slot on a full tie
  assign pop_better = !best_vld_q || (rd_exp < best_exp_q) ||
                      ((rd_exp == best_exp_q) && (rd_id < best_id_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q      <= '0;
      chk_q      <= 1'b0;
      best_vld_q <= 1'b0;
      count_q    <= '0;
    end else begin
      if (cmd_i.load || cmd_i.pop_hit) begin
        ptr_q      <= '0;
        chk_q      <= 1'b0;
        best_vld_q <= 1'b0;
      end else begin
        chk_q <= cmd_i.scan_run && (ptr_q != PtrEnd);
        if (cmd_i.scan_run && (ptr_q != PtrEnd)) begin
          ptr_q <= ptr_q + 1'b1;
        end
        if (mode_q == MODE_REMOVE) begin
          if (rem_hit) begin
            best_vld_q <= 1'b1;
          end
        end else if (pop_elig && pop_better) begin
          best_vld_q <= 1'b1;
        end
      end
      if (cmd_i.load) begin
        count_q <= '0;
      end else if (cmd_i.pop_hit) begin
        count_q <= count_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    chk_slot_q <= ptr_q[IDX_W-1:0];
    if ((mode_q == MODE_REMOVE && rem_hit) ||
        (mode_q == MODE_POP && pop_elig && pop_better)) begin
      best_slot_q <= chk_slot_q;
      best_exp_q  <= rd_exp;
      best_id_q   <= rd_id;
    end
  end

  always_comb begin
    valid_d = valid_q;
    if (cmd_i.do_add && !full) begin
      valid_d[free_slot] = 1'b1;
    end
    if (cmd_i.do_clear) begin
      valid_d = '0;
    end
    if ((cmd_i.rem_done && best_vld_q) || cmd_i.pop_hit) begin
      valid_d[best_slot_q] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= '0;
      next_id_q <= '0;
    end else begin
      valid_q <= valid_d;
      if (cmd_i.do_add && !full) begin
        next_id_q <= next_id_q + 1'b1;
      end
    end
  end

  // registered result port
  logic              res_vld_q;
  logic [DATA_W-1:0] res_id_q;
  logic              res_found_q, res_full_q, res_last_q;
  logic [CNT_W-1:0]  res_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else begin
      res_vld_q <= cmd_i.do_add || cmd_i.do_clear || cmd_i.rem_done ||
                   cmd_i.pop_hit || cmd_i.pop_end;
    end
  end

  always_ff @(posedge clk_i) begin
    res_id_q    <= '0;
    res_found_q <= 1'b0;
    res_full_q  <= 1'b0;
    res_cnt_q   <= '0;
    res_last_q  <= 1'b1;
    if (cmd_i.do_add) begin
      res_id_q   <= full ? '0 : next_id_q;
      res_full_q <= full;
    end
    if (cmd_i.rem_done) begin
      res_id_q    <= jid_q;
      res_found_q <= best_vld_q;
    end
    if (cmd_i.pop_hit) begin
      res_id_q    <= best_id_q;
      res_found_q <= 1'b1;
      res_last_q  <= 1'b0;
    end
    if (cmd_i.pop_end) begin
      res_cnt_q <= CNT_W'(count_q);
    end
  end

  assign result_valid_o  = res_vld_q;
  assign result_id_o     = res_id_q;
  assign found_o         = res_found_q;
  assign full_error_o    = res_full_q;
  assign expired_count_o = res_cnt_q;
  assign last_o          = res_last_q;

  assign sts_o.mode      = mode_q;
  assign sts_o.scan_done = (ptr_q == PtrEnd) && !chk_q;
  assign sts_o.best_vld  = best_vld_q;

endmodule
